// ===== hdl/irt_pkg.sv =====
// ---------------------------------------------------------------------------
// irt_pkg
// Shared types and constants of the interval reservation table.
// ---------------------------------------------------------------------------
package irt_pkg;

  // Fixed widths of the channel fields.
  localparam int ROW_IN_W   = 8;
  localparam int SEAT_IN_W  = 16;
  localparam int OWNER_IN_W = 16;

  // Operation codes.
  localparam logic OP_RESERVE = 1'b0;
  localparam logic OP_LOOKUP  = 1'b1;

  // One request word as it enters the datapath.
  typedef struct packed {
    logic                  opcode;
    logic [ROW_IN_W-1:0]   row;
    logic [SEAT_IN_W-1:0]  seat_first;
    logic [SEAT_IN_W-1:0]  seat_last;
    logic [OWNER_IN_W-1:0] owner_id;
  } req_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture request, read fill count
    logic fill;    // settle fill count and prechecks
    logic scan;    // walk stored intervals of the row
    logic commit;  // append an accepted reservation
    logic emit;    // load the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic done;      // scan finished
    logic out_free;  // output register can take a word
  } stat_t;

endpackage

// ===== hdl/irt_req_if.sv =====
// ---------------------------------------------------------------------------
// irt_req_if
// Request channel: valid/ready handshake with the request fields.
// ---------------------------------------------------------------------------
interface irt_req_if;
  logic                           valid;
  logic                           ready;
  logic                           opcode;
  logic [irt_pkg::ROW_IN_W-1:0]   row;
  logic [irt_pkg::SEAT_IN_W-1:0]  seat_first;
  logic [irt_pkg::SEAT_IN_W-1:0]  seat_last;
  logic [irt_pkg::OWNER_IN_W-1:0] owner_id;

  modport source (output valid, opcode, row, seat_first, seat_last, owner_id,
                  input ready);
  modport sink   (input valid, opcode, row, seat_first, seat_last, owner_id,
                  output ready);
endinterface

// ===== hdl/irt_rsp_if.sv =====
// ---------------------------------------------------------------------------
// irt_rsp_if
// Result channel: valid/ready handshake with the result fields.
// ---------------------------------------------------------------------------
interface irt_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           ok;
  logic [irt_pkg::OWNER_IN_W-1:0] owner_out;

  modport source (output valid, ok, owner_out, input ready);
  modport sink   (input valid, ok, owner_out, output ready);
endinterface

// ===== hdl/interval_reservation_table_top.sv =====
// ---------------------------------------------------------------------------
// interval_reservation_table_top
// Per-row table of reserved seat intervals with owner lookup.
// ---------------------------------------------------------------------------
// Each row holds up to SLOTS closed seat intervals, each with an owner. A
// reserve word is appended when its interval is well ordered, its row has room
// and it overlaps no stored interval of the row; a lookup word returns the
// owner of the first stored interval holding the seat. Every request gives one
// result word. A request reads the stored intervals of the row in order (up
// to the row's fill, at most SLOTS; when a lookup or overlap hits early, the
// scan stops after reading one interval past the hit). A rejected reserve or
// any word to an empty row reads no interval. The slot memory has one read
// port and is read one interval per cycle. The next request is taken once the
// result sits in the output register; a stalled result then holds back the
// next request's result, and so that request holds off the input. The slot
// memory needs no clearing after reset: per-row fill counts with valid bits
// make a row empty at once.
module interval_reservation_table_top #(
  parameter int ROWS       = 256,
  parameter int SLOTS      = 16,
  parameter int SEAT_BITS  = 16,
  parameter int OWNER_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  irt_req_if.sink    in_req,
  irt_rsp_if.source  out_rsp
);
  import irt_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  req_t  req;

  assign req.opcode     = in_req.opcode;
  assign req.row        = in_req.row;
  assign req.seat_first = in_req.seat_first;
  assign req.seat_last  = in_req.seat_last;
  assign req.owner_id   = in_req.owner_id;

  irt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  irt_dpath #(
    .ROWS       (ROWS),
    .SLOTS      (SLOTS),
    .SEAT_BITS  (SEAT_BITS),
    .OWNER_BITS (OWNER_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .req       (req),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .out_ok    (out_rsp.ok),
    .out_owner (out_rsp.owner_out)
  );

endmodule

// ===== hdl/irt_ctrl.sv =====
// ---------------------------------------------------------------------------
// irt_ctrl
// Sequencer of the table: steps one request through fill read, slot scan,
// commit and result hand-off.
// ---------------------------------------------------------------------------
module irt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  irt_pkg::stat_t stat,
  output irt_pkg::cmd_t  cmd
);
  import irt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_SCAN,
    S_COMMIT,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   rdy_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && rdy_r) begin
          cmd.load  = 1'b1;
          state_nxt = S_FILL;
        end
      end
      S_FILL: begin
        cmd.fill  = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.done) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rdy_r   <= 1'b1;
    end else begin
      state_r <= state_nxt;
      rdy_r   <= (state_nxt == S_IDLE);
    end
  end

  assign in_ready = rdy_r;

endmodule

// ===== hdl/irt_dpath.sv =====
// ---------------------------------------------------------------------------
// irt_dpath
// Datapath of the table: slot memory, per-row fill counts, the interval
// compare and the output register.
// ---------------------------------------------------------------------------
module irt_dpath #(
  parameter int ROWS       = 256,
  parameter int SLOTS      = 16,
  parameter int SEAT_BITS  = 16,
  parameter int OWNER_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  irt_pkg::cmd_t                  cmd,
  output irt_pkg::stat_t                 stat,
  input  irt_pkg::req_t                  req,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_ok,
  output logic [irt_pkg::OWNER_IN_W-1:0] out_owner
);
  import irt_pkg::*;

  localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int FILL_W  = $clog2(SLOTS + 1);
  localparam int ENTRIES = ROWS * SLOTS;
  localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int ENTRY_W = 2 * SEAT_BITS + OWNER_BITS;

  // Storage.
  logic [ENTRY_W-1:0] slot_mem [ENTRIES];
  logic [FILL_W-1:0]  fill_mem [ROWS];
  logic [ROWS-1:0]    fill_vld_r;

  // Captured request.
  logic                  op_r;
  logic                  row_ok_r;
  logic [ROW_W-1:0]      row_idx_r;
  logic [SEAT_BITS-1:0]  first_r;
  logic [SEAT_BITS-1:0]  last_r;
  logic [OWNER_BITS-1:0] owner_r;

  // Scan state.
  logic [FILL_W-1:0]     fill_rd_r;
  logic                  vld_rd_r;
  logic [FILL_W-1:0]     fill_r;
  logic [FILL_W-1:0]     lim_r;
  logic [FILL_W-1:0]     idx_r;
  logic                  rej_r;
  logic                  pend_r;
  logic                  hit_r;
  logic [OWNER_BITS-1:0] hit_own_r;
  logic [ENTRY_W-1:0]    rd_ent_r;

  // Output register.
  logic                  out_valid_r;
  logic                  out_ok_r;
  logic [OWNER_IN_W-1:0] out_owner_r;

  logic [ROW_W-1:0]      row_idx_in;
  logic                  row_ok_in;
  logic [FILL_W-1:0]     fill_cur;
  logic                  rej_cur;
  logic [ADDR_W-1:0]     base_addr;
  logic [ADDR_W-1:0]     rd_addr;
  logic [ADDR_W-1:0]     wr_addr;
  logic                  issue;
  logic [SEAT_BITS-1:0]  ent_first;
  logic [SEAT_BITS-1:0]  ent_last;
  logic [OWNER_BITS-1:0] ent_owner;
  logic                  match;
  logic                  ok_w;
  logic                  wr_en;

  assign row_idx_in = ROW_W'(req.row);
  assign row_ok_in  = (int'(req.row) < ROWS);

  // A row never written reads as empty.
  assign fill_cur = vld_rd_r ? fill_rd_r : '0;
  assign rej_cur  = !row_ok_r ||
                    ((op_r == OP_RESERVE) &&
                     ((first_r > last_r) || (fill_cur >= FILL_W'(SLOTS))));

  assign base_addr = ADDR_W'(row_idx_r) * ADDR_W'(SLOTS);
  assign rd_addr   = base_addr + ADDR_W'(idx_r);
  assign wr_addr   = base_addr + ADDR_W'(fill_r);
  assign issue     = cmd.scan && (idx_r < lim_r) && !hit_r;

  assign {ent_first, ent_last, ent_owner} = rd_ent_r;

  // Reserve looks for any overlap; lookup looks for containment of the seat.
  always_comb begin
    if (op_r == OP_RESERVE) begin
      match = (ent_first <= last_r) && (first_r <= ent_last);
    end else begin
      match = (ent_first <= first_r) && (first_r <= ent_last);
    end
  end

  assign ok_w  = (op_r == OP_LOOKUP) ? hit_r : (!rej_r && !hit_r);
  assign wr_en = cmd.commit && (op_r == OP_RESERVE) && ok_w;

  // Memories.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fill_rd_r <= fill_mem[row_idx_in];
    end
    if (wr_en) begin
      fill_mem[row_idx_r] <= fill_r + FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_ent_r <= slot_mem[rd_addr];
    end
    if (wr_en) begin
      slot_mem[wr_addr] <= {first_r, last_r, owner_r};
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= req.opcode;
      row_ok_r  <= row_ok_in;
      row_idx_r <= row_idx_in;
      first_r   <= SEAT_BITS'(req.seat_first);
      last_r    <= SEAT_BITS'(req.seat_last);
      owner_r   <= OWNER_BITS'(req.owner_id);
      vld_rd_r  <= fill_vld_r[row_idx_in];
    end
    if (cmd.fill) begin
      fill_r <= fill_cur;
      rej_r  <= rej_cur;
      lim_r  <= rej_cur ? '0 : fill_cur;
    end
    if (cmd.scan && pend_r && !hit_r && match) begin
      hit_own_r <= ent_owner;
    end
    if (cmd.emit) begin
      out_ok_r    <= ok_w;
      out_owner_r <= ((op_r == OP_LOOKUP) && hit_r) ? OWNER_IN_W'(hit_own_r) : '0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_vld_r  <= '0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        fill_vld_r[row_idx_r] <= 1'b1;
      end
      if (cmd.fill) begin
        idx_r  <= '0;
        pend_r <= 1'b0;
        hit_r  <= 1'b0;
      end else if (cmd.scan) begin
        // The read issued here is compared in the next cycle.
        pend_r <= issue;
        if (issue) begin
          idx_r <= idx_r + FILL_W'(1);
        end
        if (pend_r && match) begin
          hit_r <= 1'b1;
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.done     = !pend_r && (hit_r || (idx_r >= lim_r));
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_ok    = out_ok_r;
  assign out_owner = out_owner_r;

endmodule

// ===== hdl/irt_checker.sv =====
// ---------------------------------------------------------------------------
// irt_checker
// Port-level checks of the interval reservation table, bound to the top level.
// ---------------------------------------------------------------------------
module irt_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           out_ok,
  input logic [irt_pkg::OWNER_IN_W-1:0] out_owner
);
  import irt_pkg::*;

  // A held result word keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ok) && $stable(out_owner))
    else $error("result word changed while stalled");

  // One request at a time: after a word is taken, ready drops.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in progress");

  // A failed request reports no owner.
  a_fail_no_owner: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_owner == '0)
    else $error("owner reported on a failed request");

  // A new result appears only while a request is in progress.
  a_result_from_request: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared with no request in progress");

endmodule

bind interval_reservation_table_top irt_checker u_irt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_req.valid),
  .in_ready  (in_req.ready),
  .out_valid (out_rsp.valid),
  .out_ready (out_rsp.ready),
  .out_ok    (out_rsp.ok),
  .out_owner (out_rsp.owner_out)
);
